[rtl/assert_macros.svh]
// shared assertion forms, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define SSC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ssc assertion failed");

// consequence holds in the same cycle as the trigger
`define SSC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssc assertion failed");

// consequence holds in the cycle after the trigger
`define SSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssc assertion failed");

`endif

[rtl/ssc_pkg.sv]
package ssc_pkg;

  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] LAST_POSITION = 7'd78;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef logic [1:0] target_t;
  localparam target_t TGT_CURRENT = 2'd0;
  localparam target_t TGT_PERIOD  = 2'd1;
  localparam target_t TGT_DUTY    = 2'd2;
  localparam target_t TGT_NONE    = 2'd3;

  // one classified word on its way from the front to the back
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       is_cr;
    logic       is_digit;
  } cls_item_t;

endpackage

[rtl/serial_setpoint_command_decoder_core.sv]
// result path: the carriage return (or the overflowing word) is accepted into
//   the queue, then taken by the back, which registers the result and offers it
// throughput: one word per cycle while the result slot is free or draining
// a two-entry queue and the result register decouple input and output stalls
// reset: synchronous, active low; clears the queue, the line state and out_valid
module serial_setpoint_command_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_target,
  output logic [15:0] out_setting_value
);
  import ssc_pkg::*;

  logic      q_full;
  logic      push;
  cls_item_t push_item;
  logic      head_valid;
  cls_item_t head_item;
  logic      pop;

  ssc_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  ssc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  ssc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_item         (head_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target        (out_target),
    .out_setting_value (out_setting_value)
  );

endmodule

[rtl/ssc_front.sv]
module ssc_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  input  logic              q_full,
  output logic              push,
  output ssc_pkg::cls_item_t push_item
);
  import ssc_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.rx_byte  = in_rx_byte;
    push_item.is_cr    = (in_rx_byte == CHAR_CR);
    push_item.is_digit = (in_rx_byte >= CHAR_ZERO) && (in_rx_byte <= CHAR_NINE);
  end

endmodule

[rtl/ssc_queue.sv]
`include "assert_macros.svh"

module ssc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssc_pkg::cls_item_t push_item,
  output logic               full,
  output logic               head_valid,
  output ssc_pkg::cls_item_t head_item,
  input  logic               pop
);
  import ssc_pkg::*;

  cls_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `SSC_ASSERT_ALWAYS(a_count_range, count_r != 2'd3)
  `SSC_ASSERT_SAME(a_ptr_match, count_r == 2'd0 || count_r == 2'd2, wr_ptr_r == rd_ptr_r)
  `SSC_ASSERT_NEXT(a_count_track, push && !do_pop, count_r == $past(count_r) + 2'd1)

endmodule

[rtl/ssc_back.sv]
`include "assert_macros.svh"

module ssc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  ssc_pkg::cls_item_t head_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_target,
  output logic [15:0]        out_setting_value
);
  import ssc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       first_r, first_nxt;
  logic [7:0]       second_r, second_nxt;
  logic [15:0]      accum_r, accum_nxt;
  logic             ended_r, ended_nxt;
  logic             out_valid_r, out_valid_nxt;
  target_t          out_target_r;
  logic [15:0]      out_value_r;

  logic             line_end;
  target_t          tgt;
  logic             emit;
  logic [15:0]      accum_x10;

  // the back moves on whenever the result slot is free or being drained
  assign pop = head_valid && (!out_valid_r || out_ready);

  assign line_end  = head_item.is_cr || (pos_r > LAST_POSITION);
  assign accum_x10 = (accum_r << 3) + (accum_r << 1);

  always_comb begin
    tgt = TGT_NONE;
    if (pos_r >= 7'd2 && first_r == CHAR_LOW_A) begin
      unique case (second_r)
        CHAR_I:  tgt = TGT_CURRENT;
        CHAR_P:  tgt = TGT_PERIOD;
        CHAR_D:  tgt = TGT_DUTY;
        default: tgt = TGT_NONE;
      endcase
    end
  end

  assign emit = pop && line_end && (tgt != TGT_NONE);

  always_comb begin
    pos_nxt    = pos_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    accum_nxt  = accum_r;
    ended_nxt  = ended_r;
    if (pop) begin
      if (line_end) begin
        pos_nxt    = '0;
        first_nxt  = '0;
        second_nxt = '0;
        accum_nxt  = '0;
        ended_nxt  = 1'b0;
      end else begin
        if (pos_r == 7'd0) begin
          first_nxt = head_item.rx_byte;
        end else if (pos_r == 7'd1) begin
          second_nxt = head_item.rx_byte;
        end else if (!ended_r) begin
          if (head_item.is_digit) begin
            accum_nxt = accum_x10 + {12'd0, head_item.rx_byte[3:0]};
          end else begin
            ended_nxt = 1'b1;
          end
        end
        pos_nxt = pos_r + 7'd1;
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      accum_r     <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      first_r     <= first_nxt;
      second_r    <= second_nxt;
      accum_r     <= accum_nxt;
      ended_r     <= ended_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_target_r <= tgt;
      out_value_r  <= accum_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_target        = out_target_r;
  assign out_setting_value = out_value_r;

  `SSC_ASSERT_ALWAYS(a_pos_bound, pos_r <= LAST_POSITION + 7'd1)
  `SSC_ASSERT_SAME(a_ended_late, ended_r, pos_r > 7'd2)
  `SSC_ASSERT_SAME(a_target_code, out_valid_r, out_target_r != TGT_NONE)
  `SSC_ASSERT_NEXT(a_line_cleared, pop && line_end, pos_r == 7'd0 && !ended_r)

endmodule

[bench/tb_serial_setpoint_command_decoder_core.sv]
`timescale 1ns / 100ps

module tb_serial_setpoint_command_decoder_core;
  import ssc_pkg::*;

  localparam int unsigned TAIL_CYCLES     = 10;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef struct {
    target_t     target;
    logic [15:0] value;
  } setting_write_t;

  typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_target;
  logic [15:0] out_setting_value;

  // line decoder state as seen from the words accepted so far
  logic [POS_W-1:0] line_len = '0;
  logic [7:0]       lead_char = 8'h00;
  logic [7:0]       cmd_char = 8'h00;
  logic [15:0]      value_acc = 16'h0000;
  logic             digits_done = 1'b0;

  setting_write_t pending_writes[$];

  ready_style_t ready_style = READY_ALWAYS;
  logic [15:0]  stall_pattern = 16'hFFFF;
  bit           hold_off_req = 1'b0;
  bit           gaps_on = 1'b0;
  int unsigned  burst_left = 0;

  int unsigned words_issued = 0;
  int unsigned words_accepted = 0;
  int unsigned lines_done = 0;
  int unsigned writes_checked[3] = '{0, 0, 0};
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  serial_setpoint_command_decoder_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target        (out_target),
    .out_setting_value (out_setting_value)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d writes still outstanding", $time, pending_writes.size());
      $display("tb_serial_setpoint_command_decoder_core failed");
      $finish;
    end
  end

  // one accepted word moves the line state and may finish a line
  task automatic decode_char(input logic [7:0] ch);
    setting_write_t w;
    logic           hit;
    if (ch == CHAR_CR || line_len > LAST_POSITION) begin
      hit = 1'b1;
      case (cmd_char)
        CHAR_I: w.target = TGT_CURRENT;
        CHAR_P: w.target = TGT_PERIOD;
        CHAR_D: w.target = TGT_DUTY;
        default: hit = 1'b0;
      endcase
      if (line_len < 2 || lead_char != CHAR_LOW_A) hit = 1'b0;
      if (hit) begin
        w.value = value_acc;
        pending_writes.push_back(w);
      end
      lines_done++;
      line_len    = '0;
      lead_char   = 8'h00;
      cmd_char    = 8'h00;
      value_acc   = 16'h0000;
      digits_done = 1'b0;
    end else begin
      if (line_len == 0) begin
        lead_char = ch;
      end else if (line_len == 1) begin
        cmd_char = ch;
      end else if (!digits_done) begin
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
          value_acc = value_acc * 16'd10 + 16'(ch - CHAR_ZERO);
        end else begin
          digits_done = 1'b1;
        end
      end
      line_len = line_len + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      words_accepted++;
      decode_char(in_rx_byte);
    end
  end

  always @(posedge clk) begin
    setting_write_t w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_writes.size() == 0) begin
        $display("%0t: unexpected write, expected none, got target %0d value %0d",
                 $time, out_target, out_setting_value);
        fail_count++;
      end else begin
        w = pending_writes.pop_front();
        if (out_target !== w.target) begin
          $display("%0t: target mismatch, expected %0d, got %0d", $time, w.target, out_target);
          fail_count++;
        end
        if (out_setting_value !== w.value) begin
          $display("%0t: value mismatch, expected %0d, got %0d",
                   $time, w.value, out_setting_value);
          fail_count++;
        end
        if (w.target <= TGT_DUTY) writes_checked[w.target]++;
      end
    end
  end

  // receiver: stall style set by the running test, plus a one-off long hold-off
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_OFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
      end
      case (ready_style)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
        default: begin
          out_ready <= stall_pattern[0];
          stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
      endcase
    end
  end

  // offer one word, holding it until accepted; gaps fall between bursts
  task automatic send_char(input logic [7:0] ch);
    int unsigned gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left != 0) burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= ch;
    words_issued++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input string body);
    int i;
    for (i = 0; i < body.len(); i++) send_char(body[i]);
  endtask

  task automatic send_line(input string body);
    send_text(body);
    send_char(CHAR_CR);
  endtask

  task automatic send_digit();
    send_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // stop offering and let every expected write come out
  task automatic wait_for_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_line();
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      send_char(CHAR_LOW_A);
      case ($urandom_range(0, 2))
        0: send_char(CHAR_I);
        1: send_char(CHAR_P);
        default: send_char(CHAR_D);
      endcase
      // mostly short numbers, sometimes long enough to wrap
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 5);
      repeat (n) send_digit();
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_char(8'($urandom));
      end
      send_char(CHAR_CR);
    end else if (kind < 85) begin
      send_char(($urandom_range(0, 1) != 0) ? CHAR_LOW_A : 8'($urandom));
      send_char(8'($urandom));
      repeat ($urandom_range(0, 4)) send_digit();
      send_char(CHAR_CR);
    end else if (kind < 99) begin
      repeat ($urandom_range(0, 10)) send_char(8'($urandom));
      send_char(CHAR_CR);
    end else begin
      // runs up to or past the line limit, no carriage return
      send_char(CHAR_LOW_A);
      send_char(CHAR_P);
      repeat ($urandom_range(77, 85)) begin
        if ($urandom_range(0, 3) != 0) send_digit();
        else send_char(8'($urandom));
      end
    end
  endtask

  task automatic test_directed_lines();
    ready_style = READY_ALWAYS;
    gaps_on = 1'b0;
    send_line("");
    send_line("a");
    send_line("aI");
    send_line("aD65537");
    send_text("aP4");
    send_char(8'h00);
    send_line("7");
    send_text("a");
    send_char(8'hFF);
    send_line("1");
    send_char(8'h00);
    send_line("I");
    wait_for_writes();
  endtask

  task automatic test_overlong_lines();
    ready_style = READY_RANDOM;
    gaps_on = 1'b1;
    // limit hit by an ordinary word, which is dropped
    send_text("aP123");
    repeat (74) send_char("x");
    send_char("Z");
    send_line("aI7");
    // limit hit by the carriage return itself, with a wrapping digit run
    send_text("aD");
    repeat (77) send_char(CHAR_NINE);
    send_char(CHAR_CR);
    send_line("aP9");
    wait_for_writes();
  endtask

  task automatic test_random_lines(input int unsigned n_words, input ready_style_t style,
                                   input bit gaps);
    int unsigned start;
    ready_style = style;
    stall_pattern = 16'($urandom) | 16'h0001;
    gaps_on = gaps;
    burst_left = 0;
    start = words_issued;
    while (words_issued - start < n_words) send_random_line();
    wait_for_writes();
  endtask

  task automatic test_output_hold_off();
    ready_style = READY_ALWAYS;
    gaps_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (30) begin
      send_char(CHAR_LOW_A);
      send_char(CHAR_D);
      repeat ($urandom_range(0, 3)) send_digit();
      send_char(CHAR_CR);
    end
    wait_for_writes();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_lines();
    test_overlong_lines();
    test_random_lines(240, READY_RANDOM, 1'b1);
    test_random_lines(240, READY_ALWAYS, 1'b0);
    test_random_lines(240, READY_PATTERN, 1'b1);
    test_output_hold_off();
    test_random_lines(110, READY_RANDOM, 1'b0);
    $display("covered %0d words in %0d lines, incl. overlong and malformed lines",
             words_accepted, lines_done);
    $display("writes checked: current %0d, period %0d, duty %0d, mismatches %0d",
             writes_checked[0], writes_checked[1], writes_checked[2], fail_count);
    if (fail_count == 0) begin
      $display("tb_serial_setpoint_command_decoder_core passed");
    end else begin
      $display("tb_serial_setpoint_command_decoder_core failed");
    end
    $finish;
  end

endmodule
